### hdl/ulpsp_pkg.sv
package ulpsp_pkg;

    // Widest length the parser accepts, in bits (range 8 to 64)
    localparam int LEN_BITS   = 32;
    // Width of the bit position of the next length group
    localparam int SHIFT_BITS = 6;
    // Seven-bit groups of the ULEB128 length
    localparam int GROUP_BITS = 7;
    // A group placed at any legal position fits in this many bits
    localparam int WIDE_BITS  = LEN_BITS + GROUP_BITS;
    // Room to zero-extend the length to the 32-bit result field
    localparam int EXT_BITS   = LEN_BITS + 32;
    // Compare width for shift positions (holds 64 + 7)
    localparam int POS_BITS   = SHIFT_BITS + 1;

    localparam logic [7:0] FLAG_EMPTY  = 8'h00;
    localparam logic [7:0] FLAG_STRING = 8'h0B;
    localparam int         MORE_BIT    = 7;

    typedef logic [LEN_BITS-1:0]   t_len;
    typedef logic [WIDE_BITS-1:0]  t_wide;
    typedef logic [SHIFT_BITS-1:0] t_shift;
    typedef logic [POS_BITS-1:0]   t_pos;

    localparam t_len   LEN_ONE     = t_len'(1);
    localparam t_shift GROUP_STEP  = t_shift'(GROUP_BITS);
    localparam t_pos   GROUP_POS   = t_pos'(GROUP_BITS);
    localparam t_pos   LEN_POS     = t_pos'(LEN_BITS);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LEN,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_EMPTY,
        KIND_BADFLAG,
        KIND_OVERFLOW
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic        last;
        logic [31:0] string_length;
    } t_result;

endpackage

### hdl/uleb128_prefixed_string_parser_top.sv
// Parses length-prefixed strings from a byte stream: flag 0x00 gives an empty-string
// result, flag 0x0B is followed by a ULEB128 length and that many payload bytes, each
// emitted with kind 0 and last set on the final one; a zero length also gives an empty
// string, any other flag a bad-flag error, and a length that does not fit in LEN_BITS
// (ulpsp_pkg) a length-overflow error, after which the parser looks for a new flag.
// One byte is taken every clock while the output side keeps up; each byte passes an
// input register and the parse logic into the result register, which holds its
// result, if the byte gives one, on the outputs until the output side takes it.
// While a result waits for the output side, the held byte waits and the input stalls.
module uleb128_prefixed_string_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_last,
    output logic [31:0] o_string_length
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               step;
    logic               out_valid;
    ulpsp_pkg::t_result result;

    // Parse the held byte once the result slot is free or being drained
    assign step       = r_in_valid && (!out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_valid || step);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    ulpsp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_out_ready (i_out_ready),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign o_out_valid     = out_valid;
    assign o_kind          = result.kind;
    assign o_data_byte     = result.data_byte;
    assign o_last          = result.last;
    assign o_string_length = result.string_length;

endmodule

### hdl/ulpsp_parse.sv
module ulpsp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output ulpsp_pkg::t_result  o_result
);

    ulpsp_pkg::t_phase  r_phase, n_phase;
    ulpsp_pkg::t_len    r_accum, n_accum;
    ulpsp_pkg::t_shift  r_shift, n_shift;
    ulpsp_pkg::t_len    r_bytes_left, n_bytes_left;
    logic               r_out_valid;
    ulpsp_pkg::t_result r_out;

    logic               emit;
    ulpsp_pkg::t_result res;

    ulpsp_pkg::t_wide   grp_wide;
    ulpsp_pkg::t_pos    pos;
    ulpsp_pkg::t_pos    pos_next;
    ulpsp_pkg::t_len    accum_new;
    logic               more;
    logic               over;
    logic               fin;
    logic [ulpsp_pkg::EXT_BITS-1:0] accum_ext;

    // Length group placed at its bit position, overflow checks
    assign more      = i_byte[ulpsp_pkg::MORE_BIT];
    assign grp_wide  = ulpsp_pkg::t_wide'(i_byte[ulpsp_pkg::GROUP_BITS-1:0]) << r_shift;
    assign pos       = ulpsp_pkg::t_pos'(r_shift);
    assign pos_next  = pos + ulpsp_pkg::GROUP_POS;
    assign accum_new = r_accum | grp_wide[ulpsp_pkg::LEN_BITS-1:0];
    assign over      = (pos >= ulpsp_pkg::LEN_POS)
                    || (|grp_wide[ulpsp_pkg::WIDE_BITS-1:ulpsp_pkg::LEN_BITS])
                    || (more && (pos_next >= ulpsp_pkg::LEN_POS));
    assign fin       = (r_bytes_left[ulpsp_pkg::LEN_BITS-1:1] == '0);
    assign accum_ext = {32'b0, r_accum};

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ulpsp_pkg::PH_FLAG;
            r_accum      <= '0;
            r_shift      <= '0;
            r_bytes_left <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_accum      <= n_accum;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
        end
    end

    // Next state and result for the byte in the input register
    always_comb begin
        n_phase           = ulpsp_pkg::PH_FLAG;
        n_accum           = '0;
        n_shift           = '0;
        n_bytes_left      = '0;
        emit              = 1'b0;
        res.kind          = ulpsp_pkg::KIND_DATA;
        res.data_byte     = 8'h00;
        res.last          = 1'b1;
        res.string_length = 32'h0;
        unique case (r_phase)
            ulpsp_pkg::PH_LEN: begin
                if (over) begin
                    emit     = 1'b1;
                    res.kind = ulpsp_pkg::KIND_OVERFLOW;
                end else if (more) begin
                    n_phase = ulpsp_pkg::PH_LEN;
                    n_accum = accum_new;
                    n_shift = r_shift + ulpsp_pkg::GROUP_STEP;
                end else if (accum_new == '0) begin
                    emit     = 1'b1;
                    res.kind = ulpsp_pkg::KIND_EMPTY;
                end else begin
                    n_phase      = ulpsp_pkg::PH_DATA;
                    n_accum      = accum_new;
                    n_bytes_left = accum_new;
                end
            end
            ulpsp_pkg::PH_DATA: begin
                emit              = 1'b1;
                res.data_byte     = i_byte;
                res.last          = fin;
                res.string_length = accum_ext[31:0];
                if (!fin) begin
                    n_phase      = ulpsp_pkg::PH_DATA;
                    n_accum      = r_accum;
                    n_bytes_left = r_bytes_left - ulpsp_pkg::LEN_ONE;
                end
            end
            default: begin
                // flag byte; the unused phase code is read as a flag too
                if (i_byte == ulpsp_pkg::FLAG_EMPTY) begin
                    emit     = 1'b1;
                    res.kind = ulpsp_pkg::KIND_EMPTY;
                end else if (i_byte == ulpsp_pkg::FLAG_STRING) begin
                    n_phase = ulpsp_pkg::PH_LEN;
                end else begin
                    emit     = 1'b1;
                    res.kind = ulpsp_pkg::KIND_BADFLAG;
                end
            end
        endcase
    end

    // Result register; a step only happens when this slot is free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_step && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
